>>> hw/rtl/vertex_transform_project_macros.svh
// Assertion helpers for vertex_transform_project.sv.
`ifndef VERTEX_TRANSFORM_PROJECT_MACROS_SVH
`define VERTEX_TRANSFORM_PROJECT_MACROS_SVH

// Same-cycle implication, sampled on aclk and disabled during reset.
`define VTP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vtp assertion failed");

// Next-cycle implication, sampled on aclk and disabled during reset.
`define VTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vtp assertion failed");

`endif

>>> hw/rtl/vtp_pkg.sv
`timescale 1ns / 1ps
package vtp_pkg;

    localparam int COORD_W = 24;
    localparam int PROD_W  = COORD_W + 16;
    localparam int SUM_W   = ((PROD_W > 34) ? PROD_W : 34) + 2;
    localparam int NUM_W   = SUM_W + 13;
    localparam int DEP_W   = SUM_W + 1;
    localparam int QB      = 17;
    localparam int REM_W   = DEP_W + QB;
    localparam int NEAR_Q25 = 1677722;
    localparam int CENTER_X = 320;
    localparam int CENTER_Y = 240;
    localparam int TRANS_SHIFT = 18;

    typedef enum logic [1:0] {
        REG_ROW_X = 2'd0,
        REG_ROW_Y = 2'd1,
        REG_ROW_Z = 2'd2,
        REG_FOCAL = 2'd3
    } vtp_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
    } vtp_in_t;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               visible;
    } vtp_out_t;

    typedef struct packed {
        logic visible;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
    } vtp_flags_t;

    function automatic logic signed [15:0] matrix_entry(input logic [63:0] row,
                                                        input int unsigned k);
        matrix_entry = row[16*k +: 16];
    endfunction

endpackage

>>> hw/rtl/vtp_transform.sv
`timescale 1ns / 1ps
module vtp_transform import vtp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [3:0]        en,
    input  logic              in_valid,
    input  vtp_in_t           in_data,
    input  logic [63:0]       row_x,
    input  logic [63:0]       row_y,
    input  logic [63:0]       row_z,
    input  logic [11:0]       focal,
    output logic [3:0]        valid,
    output logic [REM_W-1:0]  rem_x,
    output logic [REM_W-1:0]  rem_y,
    output logic [DEP_W-1:0]  dep,
    output vtp_flags_t        flags
);

    logic [3:0] valid_reg;

    logic signed [PROD_W-1:0] prod_reg  [0:2][0:2];
    logic signed [PROD_W-1:0] prod_next [0:2][0:2];
    logic signed [15:0]       trans_reg [0:2];
    logic signed [15:0]       trans_next[0:2];
    logic signed [SUM_W-1:0]  sum_reg   [0:2];
    logic signed [SUM_W-1:0]  sum_next  [0:2];
    logic signed [NUM_W-1:0]  num_x_reg, num_x_next, num_y_reg, num_y_next;
    logic signed [DEP_W-1:0]  dep3_reg, dep3_next;
    logic                     vis3_reg, vis3_next;
    logic [REM_W-1:0]         rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [DEP_W-1:0]         dep_reg, dep_next;
    vtp_flags_t               flags_reg, flags_next;

    logic [63:0]              rows [0:2];
    logic signed [COORD_W-1:0] vin [0:2];
    logic [NUM_W-1:0]         mag_x, mag_y;
    logic [REM_W-1:0]         limit;

    assign rows[0] = row_x;
    assign rows[1] = row_y;
    assign rows[2] = row_z;
    assign vin[0]  = in_data.vertex_x;
    assign vin[1]  = in_data.vertex_y;
    assign vin[2]  = in_data.vertex_z;

    // Stage 1: the nine matrix products.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                prod_next[r][k] = PROD_W'(matrix_entry(rows[r], k)) * PROD_W'(vin[k]);
            end
            trans_next[r] = matrix_entry(rows[r], 3);
        end
    end

    // Stage 2: row sums, the translation lifted from Q7 to Q25.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum_next[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                        + SUM_W'(prod_reg[r][2]) + (SUM_W'(trans_reg[r]) <<< TRANS_SHIFT);
        end
    end

    // Stage 3: numerators scaled by the focal length, depth and near-plane test.
    always_comb begin
        num_x_next = NUM_W'(sum_reg[0]) * NUM_W'($signed({1'b0, focal}));
        num_y_next = NUM_W'(sum_reg[1]) * NUM_W'($signed({1'b0, focal}));
        dep3_next  = -DEP_W'(sum_reg[2]);
        vis3_next  = dep3_next >= DEP_W'(NEAR_Q25);
    end

    // Stage 4: magnitudes for the divider and the check for a quotient too large to matter.
    always_comb begin
        mag_x = num_x_reg[NUM_W-1] ? NUM_W'(-num_x_reg) : NUM_W'(num_x_reg);
        mag_y = num_y_reg[NUM_W-1] ? NUM_W'(-num_y_reg) : NUM_W'(num_y_reg);
        rem_x_next = REM_W'(mag_x);
        rem_y_next = REM_W'(mag_y);
        dep_next   = dep3_reg;
        limit      = {dep3_reg, {QB{1'b0}}};
        flags_next.visible = vis3_reg;
        flags_next.neg_x   = num_x_reg[NUM_W-1];
        flags_next.neg_y   = num_y_reg[NUM_W-1];
        flags_next.ovf_x   = rem_x_next >= limit;
        flags_next.ovf_y   = rem_y_next >= limit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) valid_reg[0] <= in_valid;
            for (int s = 1; s < 4; s++) begin
                if (en[s]) valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            prod_reg  <= prod_next;
            trans_reg <= trans_next;
        end
        if (en[1]) sum_reg <= sum_next;
        if (en[2]) begin
            num_x_reg <= num_x_next;
            num_y_reg <= num_y_next;
            dep3_reg  <= dep3_next;
            vis3_reg  <= vis3_next;
        end
        if (en[3]) begin
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            dep_reg   <= dep_next;
            flags_reg <= flags_next;
        end
    end

    assign valid = valid_reg;
    assign rem_x = rem_x_reg;
    assign rem_y = rem_y_reg;
    assign dep   = dep_reg;
    assign flags = flags_reg;

endmodule

>>> hw/rtl/vtp_div_step.sv
`timescale 1ns / 1ps
module vtp_div_step import vtp_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [REM_W-1:0]  rem_x_in,
    input  logic [REM_W-1:0]  rem_y_in,
    input  logic [QB-1:0]     q_x_in,
    input  logic [QB-1:0]     q_y_in,
    input  logic [DEP_W-1:0]  dep_in,
    input  vtp_flags_t        flags_in,
    output logic              out_valid,
    output logic [REM_W-1:0]  rem_x_out,
    output logic [REM_W-1:0]  rem_y_out,
    output logic [QB-1:0]     q_x_out,
    output logic [QB-1:0]     q_y_out,
    output logic [DEP_W-1:0]  dep_out,
    output vtp_flags_t        flags_out
);

    logic              valid_reg;
    logic [REM_W-1:0]  rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [QB-1:0]     q_x_reg, q_x_next, q_y_reg, q_y_next;
    logic [DEP_W-1:0]  dep_reg;
    vtp_flags_t        flags_reg;
    logic [REM_W-1:0]  cand;

    // One restoring step for both lanes, which share the divisor.
    always_comb begin
        cand       = REM_W'(dep_in) << SHIFT;
        rem_x_next = rem_x_in;
        rem_y_next = rem_y_in;
        q_x_next   = q_x_in;
        q_y_next   = q_y_in;
        if (rem_x_in >= cand) begin
            rem_x_next      = rem_x_in - cand;
            q_x_next[SHIFT] = 1'b1;
        end
        if (rem_y_in >= cand) begin
            rem_y_next      = rem_y_in - cand;
            q_y_next[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
            q_x_reg   <= q_x_next;
            q_y_reg   <= q_y_next;
            dep_reg   <= dep_in;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign q_x_out   = q_x_reg;
    assign q_y_out   = q_y_reg;
    assign dep_out   = dep_reg;
    assign flags_out = flags_reg;

endmodule

>>> hw/rtl/vtp_output.sv
`timescale 1ns / 1ps
module vtp_output import vtp_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [QB-1:0]  q_x,
    input  logic [QB-1:0]  q_y,
    input  vtp_flags_t     flags,
    output logic           out_valid,
    output vtp_out_t       out_data
);

    localparam int SW = QB + 3;

    logic                 valid_reg;
    vtp_out_t             data_reg, data_next;
    logic signed [SW-1:0] sq_x, sq_y, px, py;

    function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] v);
        if (v > SW'(32767))       sat16 = 16'sh7fff;
        else if (v < -SW'(32768)) sat16 = 16'sh8000;
        else                      sat16 = v[15:0];
    endfunction

    always_comb begin
        sq_x = flags.neg_x ? -SW'(q_x) : SW'(q_x);
        sq_y = flags.neg_y ? -SW'(q_y) : SW'(q_y);
        px   = SW'(CENTER_X) + sq_x;
        py   = SW'(CENTER_Y) - sq_y;
        data_next.visible  = flags.visible;
        data_next.screen_x = sat16(px);
        data_next.screen_y = sat16(py);
        // A quotient beyond the divider's range saturates by its sign alone.
        if (flags.ovf_x) data_next.screen_x = flags.neg_x ? 16'sh8000 : 16'sh7fff;
        if (flags.ovf_y) data_next.screen_y = flags.neg_y ? 16'sh7fff : 16'sh8000;
        if (!flags.visible) begin
            data_next.screen_x = '0;
            data_next.screen_y = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hw/rtl/vertex_transform_project.sv
`timescale 1ns / 1ps
// Channel   Ports                          Moves
// input     s_valid, s_ready, s_data       one model-space vertex item
// result    m_valid, m_ready, m_data       one screen-space result item
// config    cfg_we, cfg_index, cfg_data    register write, no wait
// One item enters per cycle unless all stages are full and m_ready is low.
// Stages: four transform, seventeen one-quotient-bit divider steps, one output.
// Each stage holds its item until the next one is free, so bubbles close up
// and a stalled result does not stop the input while a stage is empty.
// Reset is synchronous on aresetn low: valid bits clear, config registers reset.
`include "vertex_transform_project_macros.svh"
module vertex_transform_project import vtp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  vtp_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output vtp_out_t    m_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int NS = 4 + QB + 1;

    logic [63:0] row_x_reg, row_y_reg, row_z_reg;
    logic [11:0] focal_reg;

    logic [NS-1:0] v;
    logic [NS:0]   en;

    logic [REM_W-1:0] rem_x [0:QB];
    logic [REM_W-1:0] rem_y [0:QB];
    logic [QB-1:0]    q_x   [0:QB];
    logic [QB-1:0]    q_y   [0:QB];
    logic [DEP_W-1:0] dep   [0:QB];
    vtp_flags_t       flg   [0:QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_x_reg <= '0;
            row_y_reg <= '0;
            row_z_reg <= '0;
            focal_reg <= 12'd256;
        end else if (cfg_we) begin
            unique case (vtp_reg_t'(cfg_index))
                REG_ROW_X: row_x_reg <= cfg_data;
                REG_ROW_Y: row_y_reg <= cfg_data;
                REG_ROW_Z: row_z_reg <= cfg_data;
                REG_FOCAL: focal_reg <= cfg_data[11:0];
                default:   ;
            endcase
        end
    end

    // A stage may load when it is empty or its item moves on.
    always_comb begin
        en[NS] = m_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = !v[s] || en[s+1];
        end
    end

    assign s_ready = en[0];

    assign q_x[0] = '0;
    assign q_y[0] = '0;

    vtp_transform u_transform (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en[3:0]),
        .in_valid (s_valid),
        .in_data  (s_data),
        .row_x    (row_x_reg),
        .row_y    (row_y_reg),
        .row_z    (row_z_reg),
        .focal    (focal_reg),
        .valid    (v[3:0]),
        .rem_x    (rem_x[0]),
        .rem_y    (rem_y[0]),
        .dep      (dep[0]),
        .flags    (flg[0])
    );

    for (genvar j = 0; j < QB; j++) begin : g_div
        vtp_div_step #(
            .SHIFT (QB - 1 - j)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en[4+j]),
            .in_valid  (v[3+j]),
            .rem_x_in  (rem_x[j]),
            .rem_y_in  (rem_y[j]),
            .q_x_in    (q_x[j]),
            .q_y_in    (q_y[j]),
            .dep_in    (dep[j]),
            .flags_in  (flg[j]),
            .out_valid (v[4+j]),
            .rem_x_out (rem_x[j+1]),
            .rem_y_out (rem_y[j+1]),
            .q_x_out   (q_x[j+1]),
            .q_y_out   (q_y[j+1]),
            .dep_out   (dep[j+1]),
            .flags_out (flg[j+1])
        );
    end

    vtp_output u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en[NS-1]),
        .in_valid  (v[NS-2]),
        .q_x       (q_x[QB]),
        .q_y       (q_y[QB]),
        .flags     (flg[QB]),
        .out_valid (v[NS-1]),
        .out_data  (m_data)
    );

    assign m_valid = v[NS-1];

    `VTP_ASSERT_IMPL(a_empty_out_ready, !m_valid, s_ready)
    `VTP_ASSERT_IMPL(a_hidden_zero, m_valid && !m_data.visible,
                     m_data.screen_x == 16'sd0 && m_data.screen_y == 16'sd0)
    `VTP_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule
